// ----- src/hbkv_pkg.sv -----
// ----------------------------------------------------------------------------
// hbkv_pkg
// Shared types and codes of the hashed banked key/value store.
// ----------------------------------------------------------------------------
package hbkv_pkg;

   localparam int KeyWidth   = 32;
   localparam int DataWidth  = 32;
   localparam int HashWidth  = 5;
   localparam int HashRows   = 32;
   localparam int ProbeWidth = 6;
   localparam int KindWidth  = 2;
   localparam int CsrWidth   = 60;
   localparam int CsrIdxWidth = 2;

   localparam logic [KindWidth-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KindWidth-1:0] KIND_STORE  = 2'd1;
   localparam logic [KindWidth-1:0] KIND_INIT   = 2'd2;

   localparam logic [CsrIdxWidth-1:0] CSR_ROWS_LOW  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_ROWS_MID  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_ROWS_HIGH = 2'd2;

   typedef struct packed {
      logic                 valid;
      logic [KeyWidth-1:0]  key;
      logic [DataWidth-1:0] data;
   } slot_type;

endpackage

// ----- src/hashed_banked_key_value_store.sv -----
// ----------------------------------------------------------------------------
// hashed_banked_key_value_store
// Key/value table with H3-hashed home bank and linear bank-stride probing.
//
// Requests enter on req_ (kind in tuser, key and value in tdata), one result
// per request leaves on rsp_. csr_ writes the three hash matrix registers
// (index 0 low rows, 1 middle rows, 2 high rows); csr_ready is always high.
// All slots sit in one memory of {valid, key, data} words with a registered
// read. A request issues its first read when it is taken and then one read
// per probed slot, all through the single memory read port; an unused kind
// finishes on its first read and reports zero probes.
// A new request is taken as soon as the previous result is in the output
// register, even if the receiver has not yet taken it. If the receiver
// stalls while a result is pending, the next request finishes its probing and
// holds until the output register frees.
// After reset the block sweeps the memory once to clear every valid bit,
// during which req_tready stays low; configuration writes are taken
// throughout. The hash registers reset to zero.
// ----------------------------------------------------------------------------
module hashed_banked_key_value_store #(
   parameter int BANKS   = 32,
   parameter int ENTRIES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [63:0]                       req_tdata,  // lookup_key, write_value
   input  logic [hbkv_pkg::KindWidth-1:0]    req_tuser,  // kind
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,  // read_value, probes, zero pad
   output logic [1:0]                        rsp_tuser,  // hit, overflow
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hbkv_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [hbkv_pkg::CsrWidth-1:0]     csr_data
);
   import hbkv_pkg::*;

   localparam int AW       = $clog2(ENTRIES);
   localparam int ChainLen = ENTRIES / BANKS;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_PROBE} state_type;

   state_type               state_ff;
   logic [AW-1:0]           clr_ff;
   logic [AW-1:0]           addr_ff;
   logic [AW-1:0]           step_ff;
   logic [KindWidth-1:0]    kind_ff;
   logic [KeyWidth-1:0]     key_ff;
   logic [DataWidth-1:0]    val_ff;
   logic                    rsp_valid_ff;
   logic [DataWidth-1:0]    rsp_value_ff;
   logic [ProbeWidth-1:0]   rsp_probes_ff;
   logic                    rsp_hit_ff;
   logic                    rsp_ovf_ff;

   logic [CsrWidth-1:0]     rows_low_ff;
   logic [CsrWidth-1:0]     rows_mid_ff;
   logic [39:0]             rows_high_ff;

   slot_type                mem [ENTRIES];
   slot_type                rd_q_ff;

   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   slot_type                wr_data;

   logic [HashWidth-1:0]    hash;
   logic [AW-1:0]           start_addr;
   logic [AW:0]             next_addr;
   logic                    last;
   logic                    match;
   logic                    done;
   logic                    finish;
   logic                    out_free;
   logic                    do_write;
   logic                    res_hit;
   logic                    res_ovf;
   logic [DataWidth-1:0]    res_value;
   logic [ProbeWidth-1:0]   res_probes;
   logic                    accept;
   logic                    rsp_load;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_low_ff  <= '0;
         rows_mid_ff  <= '0;
         rows_high_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROWS_LOW:  rows_low_ff  <= csr_data;
            CSR_ROWS_MID:  rows_mid_ff  <= csr_data;
            CSR_ROWS_HIGH: rows_high_ff <= csr_data[39:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [HashRows*HashWidth-1:0] rows;
      rows = {rows_high_ff, rows_mid_ff, rows_low_ff};
      hash = '0;
      for (int i = 0; i < HashRows; i++) begin
         if (req_tdata[i]) hash = hash ^ rows[i*HashWidth +: HashWidth];
      end
   end

   assign start_addr = AW'(hash & HashWidth'(BANKS - 1));
   assign next_addr  = {1'b0, addr_ff} + (AW+1)'(BANKS);
   assign last       = (step_ff == AW'(ChainLen - 1)) || (next_addr >= (AW+1)'(ENTRIES));
   assign match      = rd_q_ff.valid && (rd_q_ff.key == key_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_load   = (state_ff == ST_PROBE) && finish && out_free;

   always_comb begin
      done      = 1'b0;
      do_write  = 1'b0;
      res_hit   = 1'b0;
      res_value = '0;
      case (kind_ff)
         KIND_LOOKUP: begin
            done      = !rd_q_ff.valid || match;
            res_hit   = match;
            res_value = match ? rd_q_ff.data : '0;
         end
         KIND_STORE: begin
            done     = !rd_q_ff.valid || match;
            do_write = done;
            res_hit  = done;
         end
         KIND_INIT: begin
            done     = !rd_q_ff.valid;
            do_write = done;
            res_hit  = done;
         end
         default: done = 1'b1;
      endcase
      finish     = done || last;
      res_ovf    = !done && (kind_ff == KIND_STORE || kind_ff == KIND_INIT);
      res_probes = (step_ff >= AW'(63)) ? ProbeWidth'(63) : ProbeWidth'(step_ff + 1'b1);
      if (kind_ff != KIND_LOOKUP && kind_ff != KIND_STORE && kind_ff != KIND_INIT) begin
         res_probes = '0;
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = start_addr;
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      case (state_ff)
         ST_CLEAR: wr_en = 1'b1;
         ST_IDLE:  rd_en = accept;
         ST_PROBE: begin
            if (!finish) begin
               rd_en   = 1'b1;
               rd_addr = next_addr[AW-1:0];
            end else if (out_free && do_write) begin
               wr_en   = 1'b1;
               wr_addr = addr_ff;
               wr_data = '{valid: 1'b1, key: key_ff, data: val_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_tready && !rsp_load) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(ENTRIES - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (accept) begin
                  addr_ff  <= start_addr;
                  step_ff  <= '0;
                  kind_ff  <= req_tuser;
                  key_ff   <= req_tdata[31:0];
                  val_ff   <= req_tdata[63:32];
                  state_ff <= ST_PROBE;
               end
            end
            ST_PROBE: begin
               if (!finish) begin
                  addr_ff <= next_addr[AW-1:0];
                  step_ff <= step_ff + 1'b1;
               end else if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= res_value;
                  rsp_probes_ff <= res_probes;
                  rsp_hit_ff    <= res_hit;
                  rsp_ovf_ff    <= res_ovf;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_probes_ff, rsp_value_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_hit_ff};

endmodule
